/* rtl/irdig_pkg.sv */
package irdig_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W = 6;
	localparam int DIGIT_LIMIT = 10;
	localparam int STEP_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	localparam logic [6:0] CHAR_MINUS = 7'd45;
	localparam logic [6:0] CHAR_ZERO = 7'd48;
	localparam logic [6:0] CHAR_A = 7'd65;

	typedef struct packed {
		logic signed [31:0] value;
		logic [RADIX_W-1:0] radix;
	} number_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic last;
	} char_t;

	typedef struct packed {
		logic start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [RADIX_W-1:0] remainder;
	} div_rsp_t;

	function automatic logic [6:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [6:0] code;
		if (d < RADIX_W'(DIGIT_LIMIT)) begin
			code = CHAR_ZERO + 7'(d);
		end else begin
			code = CHAR_A + 7'(d) - 7'(DIGIT_LIMIT);
		end
		return code;
	endfunction

endpackage

/* rtl/irdig_div.sv */
module irdig_div (
	input  logic                clk,
	input  logic                arst_n,
	input  irdig_pkg::div_req_t req,
	output irdig_pkg::div_rsp_t rsp
);

	localparam int W = irdig_pkg::VALUE_WIDTH;
	localparam int RW = irdig_pkg::RADIX_W;

	logic busy_q;
	logic done_q;
	logic [irdig_pkg::STEP_W-1:0] step_q;
	logic [W-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] div_q;

	logic [RW:0] trial;
	logic [RW:0] diff;
	logic ge;
	logic [RW-1:0] rem_next;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff = trial - {1'b0, div_q};
		ge = trial >= {1'b0, div_q};
		rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= irdig_pkg::STEP_W'(W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_no_start_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("division started while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");

endmodule

/* rtl/integer_to_radix_digits.sv */
// Each digit takes one run of the single divider (32 shift-subtract steps,
// plus start and hand-back); the characters are then emitted, sign first.
// A new number is taken only when idle, after the last character of the
// previous one has been registered; num_stall is high at all other times.
// Reset: arst_n clears the sequencer and the output valid at once.
module integer_to_radix_digits (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	output logic               num_stall,
	input  irdig_pkg::number_t num,
	output logic               chr_valid,
	input  logic               chr_stall,
	output irdig_pkg::char_t   chr
);

	localparam int W = irdig_pkg::VALUE_WIDTH;
	localparam int RW = irdig_pkg::RADIX_W;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t state_q;
	logic start_q;
	logic neg_q;
	logic chr_valid_q;
	irdig_pkg::char_t chr_q;
	logic [irdig_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0] mag_q;
	logic [RW-1:0] radix_q;
	logic [RW-1:0] dig_q [W];

	irdig_pkg::div_req_t req;
	irdig_pkg::div_rsp_t rsp;

	logic accept;
	logic chr_free;
	logic [W-1:0] raw;
	logic [W-1:0] mag_in;
	logic neg_in;
	logic [RW-1:0] radix_in;
	logic [irdig_pkg::CNT_W-1:0] cnt_m1;
	logic [irdig_pkg::IDX_W-1:0] rd_idx;
	logic dig_we;
	logic [irdig_pkg::IDX_W-1:0] dig_wa;
	logic [RW-1:0] dig_wd;

	always_comb begin
		accept = num_valid && (state_q == ST_IDLE);
		chr_free = !chr_valid_q || !chr_stall;
		raw = num.value[W-1:0];
		neg_in = raw[W-1];
		mag_in = neg_in ? (~raw + 1'b1) : raw;
		if (num.radix < irdig_pkg::RADIX_MIN) begin
			radix_in = irdig_pkg::RADIX_MIN;
		end else if (num.radix > irdig_pkg::RADIX_MAX) begin
			radix_in = irdig_pkg::RADIX_MAX;
		end else begin
			radix_in = num.radix;
		end
		cnt_m1 = cnt_q - 1'b1;
		rd_idx = cnt_m1[irdig_pkg::IDX_W-1:0];
		dig_we = 1'b0;
		dig_wa = cnt_q[irdig_pkg::IDX_W-1:0];
		dig_wd = rsp.remainder;
		if (accept && (mag_in == '0)) begin
			dig_we = 1'b1;
			dig_wa = '0;
			dig_wd = '0;
		end else if ((state_q == ST_DIV) && rsp.done) begin
			dig_we = 1'b1;
		end
	end

	assign req.start = start_q;
	assign req.dividend = mag_q;
	assign req.divisor = radix_q;

	irdig_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_q[dig_wa] <= dig_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			neg_q <= 1'b0;
			chr_valid_q <= 1'b0;
			chr_q <= '0;
			cnt_q <= '0;
			mag_q <= '0;
			radix_q <= '0;
		end else begin
			start_q <= 1'b0;
			if (chr_valid_q && !chr_stall) begin
				chr_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q <= neg_in;
						mag_q <= mag_in;
						radix_q <= radix_in;
						if (mag_in == '0) begin
							cnt_q <= irdig_pkg::CNT_W'(1);
							state_q <= ST_EMIT;
						end else begin
							cnt_q <= '0;
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (rsp.done) begin
						cnt_q <= cnt_q + 1'b1;
						mag_q <= rsp.quotient;
						if (rsp.quotient == '0) begin
							state_q <= ST_EMIT;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (chr_free) begin
						chr_valid_q <= 1'b1;
						if (neg_q) begin
							neg_q <= 1'b0;
							chr_q.char_code <= irdig_pkg::CHAR_MINUS;
							chr_q.last <= 1'b0;
						end else begin
							chr_q.char_code <= irdig_pkg::digit_char(dig_q[rd_idx]);
							chr_q.last <= (cnt_q == irdig_pkg::CNT_W'(1));
							cnt_q <= cnt_m1;
							if (cnt_q == irdig_pkg::CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign num_stall = (state_q != ST_IDLE);
	assign chr_valid = chr_valid_q;
	assign chr = chr_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_DIV))
		else $error("divider result outside division state");

	a_start_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == ST_DIV))
		else $error("division started outside division state");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q != '0))
		else $error("emitting with no digits stored");

	a_digit_room: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && rsp.done) |-> (cnt_q < irdig_pkg::CNT_W'(W)))
		else $error("digit buffer overflow");

endmodule
